// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the scanner RTL
// Same-cycle-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/llms_pkg.sv
// ----------------------------------------------------------------------------
// llms_pkg
// Codes, scan state type and the RGB565 component expansion of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package llms_pkg;

	// Operation codes of an input item
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Colour codes
	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;
	localparam int         COLORS      = 3;

	// RGB565 component masks and low fill patterns
	localparam logic [15:0] MASK_RED   = 16'hF800;
	localparam logic [15:0] MASK_GREEN = 16'h07E0;
	localparam logic [15:0] MASK_BLUE  = 16'h001F;
	localparam logic [15:0] FILL_RB    = 16'h07FF;
	localparam logic [15:0] FILL_GREEN = 16'h03FF;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_BASE  = 4'b0100,
		ST_RUN   = 4'b1000
	} state_t;

	// Expand the selected component to 12 bits: component on top, ones below, zero stays zero
	function automatic logic [11:0] expand_color(input logic [15:0] px, input logic [1:0] sel);
		logic [15:0] t;
		logic        z;
		begin
			case (sel)
				COLOR_RED: begin
					z = (px & MASK_RED) == 16'd0;
					t = (px | FILL_RB) >> 4;
				end
				COLOR_GREEN: begin
					z = (px & MASK_GREEN) == 16'd0;
					t = (16'(px << 5) | FILL_GREEN) >> 4;
				end
				default: begin
					z = (px & MASK_BLUE) == 16'd0;
					t = (16'(px << 11) | FILL_RB) >> 4;
				end
			endcase
			expand_color = z ? 12'd0 : t[11:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/led_layer_multiplex_scanner.sv
// ----------------------------------------------------------------------------
// led_layer_multiplex_scanner
// Multiplexed LED matrix scan: pixel store, scan counters and intensity stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel store to zero, one word per cycle
// over all LEDS_PER_LAYER*LAYERS*QUARTERS words, and only then raises
// in_ready. A write item is stored as it transfers. A tick item advances the
// colour, layer and quarter counters and then streams LEDS_PER_LAYER results,
// one per cycle while the output is not stalled, through the single pixel
// memory read port and the shared component expander; in_ready stays low
// after the tick transfer while the block forms the row base, issues the
// LEDS_PER_LAYER reads, moves the last word into the output register and
// returns to idle; the last result is already offered by then.
`default_nettype none

`include "assert_macros.svh"

module led_layer_multiplex_scanner #(
	parameter int LEDS_PER_LAYER = 16,
	parameter int QUARTERS       = 4,
	parameter int LAYERS         = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  pixel_index,
	input  wire logic [15:0] pixel_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       led_channel,
	output logic [11:0]      gray_value,
	output logic [1:0]       quarter_select,
	output logic [1:0]       layer_select,
	output logic [1:0]       color_select,
	output logic             last
);
	import llms_pkg::*;

	localparam int DEPTH = LEDS_PER_LAYER * LAYERS * QUARTERS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LCW   = $clog2(LEDS_PER_LAYER + 1);

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     base_q;
	logic [LCW-1:0]    iss_q;
	logic [1:0]        quarter_q, layer_q, color_q;
	logic [1:0]        quarter_d, layer_d, color_d;
	logic [2:0]        c_inc, l_inc, q_inc;

	logic [15:0]       mem [DEPTH];
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [15:0]       mem_wd;
	logic [AW-1:0]     rd_addr;

	logic              rd_valid_s1;
	logic [15:0]       rd_data_s1;
	logic [5:0]        led_s1;
	logic              last_s1;

	logic              in_xfer, wr_xfer, tick_xfer, wr_in_range;
	logic              issue, out_load, iss_done;

	// Handshake decode
	assign in_ready    = (state_q == ST_IDLE);
	assign in_xfer     = in_valid && in_ready;
	assign wr_xfer     = in_xfer && (operation == OP_WRITE);
	assign tick_xfer   = in_xfer && (operation == OP_TICK);
	assign wr_in_range = {24'd0, pixel_index} < 32'(DEPTH);

	// Advance colour, carry into layer, then into quarter
	always_comb begin
		c_inc     = {1'b0, color_q} + 3'd1;
		l_inc     = {1'b0, layer_q} + 3'd1;
		q_inc     = {1'b0, quarter_q} + 3'd1;
		color_d   = color_q;
		layer_d   = layer_q;
		quarter_d = quarter_q;
		if (c_inc >= 3'(COLORS)) begin
			color_d = 2'd0;
			if (l_inc >= 3'(LAYERS)) begin
				layer_d = 2'd0;
				quarter_d = (q_inc >= 3'(QUARTERS)) ? 2'd0 : q_inc[1:0];
			end else begin
				layer_d = l_inc[1:0];
			end
		end else begin
			color_d = c_inc[1:0];
		end
	end

	// Read issue and output load with stall
	assign iss_done = (iss_q == LCW'(LEDS_PER_LAYER));
	assign out_load = rd_valid_s1 && (!out_valid || out_ready);
	assign issue    = (state_q == ST_RUN) && !iss_done && (!rd_valid_s1 || out_load);
	assign rd_addr  = AW'(base_q + AW'(iss_q));

	// Memory write port: clearing sweep or pixel write
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = 16'd0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (wr_xfer && wr_in_range) begin
			mem_we = 1'b1;
			mem_wa = AW'(pixel_index);
			mem_wd = pixel_value;
		end
	end

	// Pixel store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			led_s1     <= 6'(iss_q);
			last_s1    <= (iss_q == LCW'(LEDS_PER_LAYER - 1));
		end
	end

	// Sequencer and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			iss_q       <= '0;
			quarter_q   <= 2'd0;
			layer_q     <= 2'd0;
			color_q     <= 2'd0;
			rd_valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (tick_xfer) begin
						quarter_q <= quarter_d;
						layer_q   <= layer_d;
						color_q   <= color_d;
						state_q   <= ST_BASE;
					end
				end
				ST_BASE: begin
					base_q  <= AW'((32'(quarter_q) * LAYERS + 32'(layer_q)) * LEDS_PER_LAYER);
					iss_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (issue) begin
						iss_q <= LCW'(iss_q + 1'b1);
					end
					if (iss_done && !rd_valid_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (out_load) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload: expand and capture selects
	always_ff @(posedge clk) begin
		if (out_load) begin
			led_channel    <= led_s1;
			gray_value     <= expand_color(rd_data_s1, color_q);
			quarter_select <= quarter_q;
			layer_select   <= layer_q;
			color_select   <= color_q;
			last           <= last_s1;
		end
	end

	// Checks
	`ASSERT_SAME(a_last_is_top_led, out_valid && last, led_channel == 6'(LEDS_PER_LAYER - 1))
	`ASSERT_SAME(a_idle_drained, in_ready, !rd_valid_s1)
	`ASSERT_NEXT(a_tick_to_base, tick_xfer, state_q == ST_BASE)
	`ASSERT_SAME(a_color_range, 1'b1, color_q != 2'd3)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: LED layer multiplex scanner testbench
// Drives pixel writes and scan ticks into the scanner through the input
// handshake. A local model of the pixel store and the colour, layer and
// quarter counters predicts every LED intensity a tick produces. Each result
// transfer is checked field by field. A short table of hand-picked items
// comes first, then random traffic aimed mostly at the layer scanned next,
// under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import llms_pkg::*;

	localparam int LEDS           = 16;
	localparam int LAYER_NUM      = 3;
	localparam int QUARTER_NUM    = 4;
	localparam int STORE_WORDS    = LEDS * LAYER_NUM * QUARTER_NUM;
	localparam int RANDOM_ITEMS   = 78;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int NO_GOLD        = -1;

	// One LED intensity as it leaves the scanner
	typedef struct packed {
		logic [5:0]  chan;
		logic [11:0] gray;
		logic [1:0]  quarter;
		logic [1:0]  layer;
		logic [1:0]  color;
		logic        last;
	} led_result_t;

	// One row of the hand-picked stimulus; gold is the LED 0 intensity of a tick
	typedef struct {
		logic        op;
		logic [7:0]  idx;
		logic [15:0] val;
		int          gold;
	} scan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        operation = OP_WRITE;
	logic [7:0]  pixel_index = 8'd0;
	logic [15:0] pixel_value = 16'd0;
	logic        out_ready = 1'b0;
	wire         in_ready;
	wire         out_valid;
	wire [5:0]   led_channel;
	wire [11:0]  gray_value;
	wire [1:0]   quarter_select;
	wire [1:0]   layer_select;
	wire [1:0]   color_select;
	wire         last;

	// Mirror of the scanner state
	logic [15:0] pixel_mirror [STORE_WORDS];
	logic [1:0]  quarter_now = 2'd0;
	logic [1:0]  layer_now = 2'd0;
	logic [1:0]  color_now = COLOR_RED;
	led_result_t pending_leds [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int n_ticks = 0;
	int n_writes = 0;
	int n_results = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;

	// Walk through: writes at the edges, each colour at its smallest and
	// largest component, out-of-range writes, and a layer wrap into quarter 1
	scan_row_t scan_rows [22] = '{
		'{OP_TICK,  8'd0,   16'h0000, 0},
		'{OP_WRITE, 8'd0,   16'hFFFF, NO_GOLD},
		'{OP_WRITE, 8'd1,   16'h0000, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'hFFF},
		'{OP_WRITE, 8'd16,  16'h0800, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'h0FF},
		'{OP_WRITE, 8'd16,  16'h0020, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'h07F},
		'{OP_WRITE, 8'd16,  16'h0001, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'h0FF},
		'{OP_WRITE, 8'd32,  16'hF800, NO_GOLD},
		'{OP_WRITE, 8'd47,  16'h07E0, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'hFFF},
		'{OP_TICK,  8'd0,   16'h0000, 0},
		'{OP_TICK,  8'd0,   16'h0000, NO_GOLD},
		'{OP_WRITE, 8'd191, 16'hFFFF, NO_GOLD},
		'{OP_WRITE, 8'd192, 16'h1234, NO_GOLD},
		'{OP_WRITE, 8'd255, 16'hAAAA, NO_GOLD},
		'{OP_WRITE, 8'd48,  16'h001F, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 0},
		'{OP_TICK,  8'd0,   16'h0000, NO_GOLD},
		'{OP_TICK,  8'd0,   16'h0000, 'hFFF}
	};

	led_layer_multiplex_scanner u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.pixel_index    (pixel_index),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_channel    (led_channel),
		.gray_value     (gray_value),
		.quarter_select (quarter_select),
		.layer_select   (layer_select),
		.color_select   (color_select),
		.last           (last)
	);

	always #2 clk = ~clk;

	// Widen one RGB565 component: component bits on top, ones below, zero stays zero
	function automatic logic [11:0] widen_component(input logic [15:0] px, input logic [1:0] sel);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = px[15:11];
		g = px[10:5];
		b = px[4:0];
		case (sel)
			COLOR_RED:   return (r == 5'd0) ? 12'd0 : {r, 7'h7F};
			COLOR_GREEN: return (g == 6'd0) ? 12'd0 : {g, 6'h3F};
			default:     return (b == 5'd0) ? 12'd0 : {b, 7'h7F};
		endcase
	endfunction

	// Advance colour, carry into layer, then into quarter
	task automatic step_scan(inout logic [1:0] q, inout logic [1:0] l, inout logic [1:0] c);
		if (c == COLOR_BLUE) begin
			c = COLOR_RED;
			if (l == 2'(LAYER_NUM - 1)) begin
				l = 2'd0;
				q = (q == 2'(QUARTER_NUM - 1)) ? 2'd0 : q + 2'd1;
			end else begin
				l = l + 2'd1;
			end
		end else begin
			c = c + 2'd1;
		end
	endtask

	// Update the mirror for one accepted item and queue the LED intensities it causes
	task automatic predict_item(input logic op, input logic [7:0] idx, input logic [15:0] val,
			input int gold);
		int base;
		led_result_t r;
		if (op == OP_WRITE) begin
			if (idx < STORE_WORDS)
				pixel_mirror[idx] = val;
			n_writes++;
		end else begin
			step_scan(quarter_now, layer_now, color_now);
			base = LEDS * (quarter_now * LAYER_NUM + layer_now);
			for (int i = 0; i < LEDS; i++) begin
				r.chan    = 6'(i);
				r.gray    = widen_component(pixel_mirror[base + i], color_now);
				r.quarter = quarter_now;
				r.layer   = layer_now;
				r.color   = color_now;
				r.last    = (i == LEDS - 1);
				if (i == 0 && gold != NO_GOLD)
					r.gray = gold[11:0];
				pending_leds.push_back(r);
			end
			n_ticks++;
		end
	endtask

	// Offer one item from the falling edge on and hold it until the transfer
	task automatic send_item(input logic op, input logic [7:0] idx, input logic [15:0] val,
			input int gold);
		if (items_sent < 40) begin
			send_idle_pct = 27;
			recv_stall_pct = 68;
		end else if (items_sent < 80) begin
			send_idle_pct = 68;
			recv_stall_pct = 27;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel_index <= idx;
		pixel_value <= val;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		predict_item(op, idx, val, gold);
		items_sent++;
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Stall the result channel at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin : check_leds
		led_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_leds.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual led %0d gray %0d",
					$time, led_channel, gray_value);
				mismatch_cnt++;
			end else begin
				want = pending_leds.pop_front();
				compare_field("led_channel", want.chan, led_channel);
				compare_field("gray_value", want.gray, gray_value);
				compare_field("quarter_select", want.quarter, quarter_select);
				compare_field("layer_select", want.layer, layer_select);
				compare_field("color_select", want.color, color_select);
				compare_field("last", want.last, last);
				n_results++;
			end
		end
	end

	// Stop the run when nothing transfers for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, pending_leds.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		logic [1:0]  nq;
		logic [1:0]  nl;
		logic [1:0]  nc;
		logic [7:0]  idx;
		logic [15:0] val;
		int          roll;
		for (int i = 0; i < STORE_WORDS; i++)
			pixel_mirror[i] = 16'd0;

		// Hold reset, then release away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Hand-picked items
		foreach (scan_rows[i])
			send_item(scan_rows[i].op, scan_rows[i].idx, scan_rows[i].val, scan_rows[i].gold);

		// Random ticks and writes, writes mostly into the layer scanned next
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				send_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					NO_GOLD);
			end else begin
				nq = quarter_now;
				nl = layer_now;
				nc = color_now;
				step_scan(nq, nl, nc);
				roll = $urandom_range(0, 99);
				if (roll < 65)
					idx = 8'(LEDS * (nq * LAYER_NUM + nl) + $urandom_range(0, LEDS - 1));
				else if (roll < 90)
					idx = 8'($urandom_range(0, STORE_WORDS - 1));
				else
					idx = 8'($urandom_range(STORE_WORDS, 255));
				val = 16'($urandom_range(0, 65535));
				// Clear one component now and then so zero intensities show up
				if ($urandom_range(0, 99) < 30) begin
					case ($urandom_range(0, 2))
						0: val = val & ~MASK_RED;
						1: val = val & ~MASK_GREEN;
						default: val = val & ~MASK_BLUE;
					endcase
				end
				send_item(OP_WRITE, idx, val, NO_GOLD);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray result
		while (pending_leds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d items (%0d scan ticks, %0d pixel writes), %0d LED results checked",
			items_sent, n_ticks, n_writes, n_results);
		$display("summary: three idle/stall mixes, %0d mismatches", mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/llms_pkg.sv
rtl/led_layer_multiplex_scanner.sv
tb/tb_top.sv
